@@ rtl/cfmt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfmt_pkg
// Shared constants for the CSR file with machine timer: command codes, CSR
// addresses, fixed register values and bit masks.
// ----------------------------------------------------------------------------
package cfmt_pkg;

	localparam int CSR_COUNT = 4096;
	localparam int CSR_AW    = $clog2(CSR_COUNT);

	localparam logic [2:0] CMD_CSR_RD   = 3'd0;
	localparam logic [2:0] CMD_CSR_WR   = 3'd1;
	localparam logic [2:0] CMD_TIMER_RD = 3'd2;
	localparam logic [2:0] CMD_TIMER_WR = 3'd3;
	localparam logic [2:0] CMD_TICK     = 3'd4;

	localparam logic [1:0] OFS_MTIME_LO = 2'd0;
	localparam logic [1:0] OFS_MTIME_HI = 2'd1;
	localparam logic [1:0] OFS_MTCMP_LO = 2'd2;
	localparam logic [1:0] OFS_MTCMP_HI = 2'd3;

	localparam logic [11:0] ADDR_MSTATUS   = 12'h300;
	localparam logic [11:0] ADDR_MISA      = 12'h301;
	localparam logic [11:0] ADDR_MIE       = 12'h304;
	localparam logic [11:0] ADDR_MIP       = 12'h344;
	localparam logic [11:0] ADDR_MVENDORID = 12'hF11;

	localparam logic [31:0] VAL_MISA        = 32'h4040_1101;
	localparam logic [31:0] VAL_MVENDORID   = 32'hff0f_ff0f;
	localparam logic [31:0] BIT_MTIP        = 32'h0000_0080;
	localparam logic [31:0] MASK_NO_MTIP    = 32'hffff_ff7f;
	localparam logic [31:0] BIT_MTIE        = 32'h0000_0080;
	localparam logic [31:0] BIT_MSTATUS_MIE = 32'h0000_0008;
	localparam logic [31:0] CAUSE_MTIMER    = 32'h8000_0007;

	localparam bit MSTATUS_OK = int'(ADDR_MSTATUS) < CSR_COUNT;
	localparam bit MIE_OK     = int'(ADDR_MIE) < CSR_COUNT;
	localparam bit MIP_OK     = int'(ADDR_MIP) < CSR_COUNT;

	localparam logic [CSR_AW-1:0] IDX_MSTATUS = ADDR_MSTATUS[CSR_AW-1:0];
	localparam logic [CSR_AW-1:0] IDX_MIE     = ADDR_MIE[CSR_AW-1:0];
	localparam logic [CSR_AW-1:0] IDX_MIP     = ADDR_MIP[CSR_AW-1:0];

endpackage

`default_nettype wire

@@ rtl/csr_file_with_machine_timer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csr_file_with_machine_timer_top
// CSR store with a RISC-V style machine timer (mtime / mtimecmp).
// ----------------------------------------------------------------------------
// Every accepted command returns exactly one result transaction. CSR state
// lives in a single-port synchronous RAM of CSR_COUNT words; mtime and
// mtimecmp are registers. After reset the RAM is cleared one word per cycle,
// so s_axis_tready stays low until every word is cleared. An item then goes
// to ST_DONE directly (CSR write, timer access, unused command, first tick,
// fixed CSR read), via ST_CSR_RD (other CSR reads) or via ST_T_MIP,
// ST_T_MIE and ST_T_MST, as the single RAM port makes an armed tick read
// MIP, MIE and MSTATUS in turn and write MIP back. A finished result
// waits in the output register while the next transaction is accepted.
module csr_file_with_machine_timer_top
	import cfmt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // csr_number, io_offset, wdata, elapsed, pad
	input  wire logic [2:0]  s_axis_tuser,  // cmd
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata   // rdata, irq_cause
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_CSR_RD = 3'd2;
	localparam logic [2:0] ST_T_MIP  = 3'd3;
	localparam logic [2:0] ST_T_MIE  = 3'd4;
	localparam logic [2:0] ST_T_MST  = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]        state_q;
	logic [CSR_AW-1:0] clr_q;
	logic              armed_q;
	logic [63:0]       mtime_q;
	logic [63:0]       mtcmp_q;
	logic              out_valid_q;
	logic [31:0]       out_rdata_q;
	logic [31:0]       out_cause_q;
	logic [31:0]       res_rdata_q;
	logic [31:0]       res_cause_q;
	logic [31:0]       mip_new_q;
	logic              mtip_q;
	logic              mie_q;

	logic [31:0] csr_mem [CSR_COUNT];
	logic [31:0] mem_rd_q;
	logic              mem_we;
	logic [CSR_AW-1:0] mem_addr;
	logic [31:0]       mem_wd;

	logic [2:0]  cmd;
	logic [11:0] csr_number;
	logic [1:0]  io_offset;
	logic [31:0] wdata;
	logic [31:0] elapsed;
	logic        acc;
	logic        csr_in_range;
	logic        csr_fixed;
	logic        out_free;
	logic        mtip;
	logic [31:0] mip_rd;

	assign cmd        = s_axis_tuser;
	assign csr_number = s_axis_tdata[11:0];
	assign io_offset  = s_axis_tdata[13:12];
	assign wdata      = s_axis_tdata[45:14];
	assign elapsed    = s_axis_tdata[77:46];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign csr_in_range  = {1'b0, csr_number} < 13'(CSR_COUNT);
	assign csr_fixed     = (csr_number == ADDR_MISA) || (csr_number == ADDR_MVENDORID);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign mtip          = (mtcmp_q != 64'd0) && (mtime_q > mtcmp_q);
	assign mip_rd        = MIP_OK ? mem_rd_q : 32'd0;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_cause_q, out_rdata_q};

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = clr_q;
		mem_wd   = 32'd0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (cmd == CMD_TICK) begin
					mem_addr = IDX_MIP;
				end else begin
					mem_addr = csr_number[CSR_AW-1:0];
					mem_we   = acc && (cmd == CMD_CSR_WR) && csr_in_range;
					mem_wd   = wdata;
				end
			end
			ST_T_MIP: mem_addr = IDX_MIE;
			ST_T_MIE: mem_addr = IDX_MSTATUS;
			ST_T_MST: begin
				mem_addr = IDX_MIP;
				mem_we   = MIP_OK;
				mem_wd   = mip_new_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			csr_mem[mem_addr] <= mem_wd;
		end
		mem_rd_q <= csr_mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			armed_q     <= 1'b0;
			mtime_q     <= 64'd0;
			mtcmp_q     <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CSR_AW'(CSR_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_DONE;
						case (cmd)
							CMD_CSR_RD: begin
								if (csr_in_range && !csr_fixed) begin
									state_q <= ST_CSR_RD;
								end
							end
							CMD_TIMER_WR: begin
								case (io_offset)
									OFS_MTIME_LO: mtime_q[31:0]  <= wdata;
									OFS_MTIME_HI: mtime_q[63:32] <= wdata;
									OFS_MTCMP_LO: mtcmp_q[31:0]  <= wdata;
									default:      mtcmp_q[63:32] <= wdata;
								endcase
							end
							CMD_TICK: begin
								armed_q <= 1'b1;
								if (armed_q) begin
									mtime_q <= mtime_q + {32'd0, elapsed};
									state_q <= ST_T_MIP;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CSR_RD: state_q <= ST_DONE;
				ST_T_MIP:  state_q <= ST_T_MIE;
				ST_T_MIE:  state_q <= ST_T_MST;
				ST_T_MST:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_rdata_q <= 32'd0;
				res_cause_q <= 32'd0;
				case (cmd)
					CMD_CSR_RD: begin
						if (csr_number == ADDR_MISA) begin
							res_rdata_q <= VAL_MISA;
						end else if (csr_number == ADDR_MVENDORID) begin
							res_rdata_q <= VAL_MVENDORID;
						end
					end
					CMD_TIMER_RD: begin
						case (io_offset)
							OFS_MTIME_LO: res_rdata_q <= mtime_q[31:0];
							OFS_MTIME_HI: res_rdata_q <= mtime_q[63:32];
							OFS_MTCMP_LO: res_rdata_q <= mtcmp_q[31:0];
							default:      res_rdata_q <= mtcmp_q[63:32];
						endcase
					end
					default: ;
				endcase
			end
			ST_CSR_RD: res_rdata_q <= mem_rd_q;
			ST_T_MIP: begin
				mip_new_q <= mtip ? (mip_rd | BIT_MTIP) : (mip_rd & MASK_NO_MTIP);
				mtip_q    <= mtip && MIP_OK;
			end
			ST_T_MIE: begin
				mie_q <= MIE_OK && ((mem_rd_q & BIT_MTIE) != 32'd0);
			end
			ST_T_MST: begin
				res_cause_q <= (mtip_q && mie_q && MSTATUS_OK
					&& ((mem_rd_q & BIT_MSTATUS_MIE) != 32'd0)) ? CAUSE_MTIMER : 32'd0;
			end
			ST_DONE: begin
				if (out_free) begin
					out_rdata_q <= res_rdata_q;
					out_cause_q <= res_cause_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/cfmt_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfmt_checker
// Port-level checks for the CSR file with machine timer, bound to the top.
// ----------------------------------------------------------------------------
module cfmt_checker
	import cfmt_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [2:0]  s_axis_tuser,   // cmd
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [63:0] m_axis_tdata    // rdata, irq_cause
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_cause_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[63:32] == 32'd0)
			|| (m_axis_tdata[63:32] == CAUSE_MTIMER))
		else $error("bad interrupt cause");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("transaction accepted while busy");

	a_tick_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_TICK) && !m_axis_tvalid
		|=> !m_axis_tvalid)
		else $error("tick result too early");

endmodule

bind csr_file_with_machine_timer_top cfmt_checker u_cfmt_checker (.*);

`default_nettype wire

@@ tb/sv/csr_file_with_machine_timer_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_file_with_machine_timer_checker
// Watches both stream channels of the CSR file with machine timer. Every
// accepted command is run through a local copy of the CSR store, mtime,
// mtimecmp and the arm flag to produce the expected result, which waits in
// a queue until the matching result transaction is compared field by field.
// ----------------------------------------------------------------------------
module csr_file_with_machine_timer_checker
	import cfmt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // csr_number, io_offset, wdata, elapsed, pad
	input  logic [2:0]  s_axis_tuser,  // cmd
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,  // rdata, irq_cause
	output int          fail_count,
	output int          pending,
	output int          checked,
	output int          irq_taken
);

	typedef struct packed {
		logic [31:0] irq_cause;
		logic [31:0] rdata;
	} csr_result_t;

	logic [31:0] csr_words [CSR_COUNT];
	logic [63:0] mtime_now;
	logic [63:0] mtime_cmp;
	bit          tick_armed;
	csr_result_t due_results [$];

	initial begin
		foreach (csr_words[i])
			csr_words[i] = '0;
		mtime_now  = '0;
		mtime_cmp  = '0;
		tick_armed = 1'b0;
		fail_count = 0;
		pending    = 0;
		checked    = 0;
		irq_taken  = 0;
	end

	function automatic logic [31:0] csr_value(input logic [11:0] addr);
		if (addr == ADDR_MISA)
			return VAL_MISA;
		if (addr == ADDR_MVENDORID)
			return VAL_MVENDORID;
		if (int'(addr) >= CSR_COUNT)
			return '0;
		return csr_words[addr];
	endfunction

	task automatic csr_store_write(input logic [11:0] addr, input logic [31:0] value);
		if (int'(addr) < CSR_COUNT)
			csr_words[addr] = value;
	endtask

	task automatic csr_timer_step(input logic [2:0] cmd, input logic [11:0] csr,
		input logic [1:0] ofs, input logic [31:0] wd, input logic [31:0] el);
		csr_result_t res;
		logic [31:0] mip;
		res = '0;
		case (cmd)
			CMD_CSR_RD: res.rdata = csr_value(csr);
			CMD_CSR_WR: csr_store_write(csr, wd);
			CMD_TIMER_RD: begin
				case (ofs)
					OFS_MTIME_LO: res.rdata = mtime_now[31:0];
					OFS_MTIME_HI: res.rdata = mtime_now[63:32];
					OFS_MTCMP_LO: res.rdata = mtime_cmp[31:0];
					default:      res.rdata = mtime_cmp[63:32];
				endcase
			end
			CMD_TIMER_WR: begin
				case (ofs)
					OFS_MTIME_LO: mtime_now[31:0]  = wd;
					OFS_MTIME_HI: mtime_now[63:32] = wd;
					OFS_MTCMP_LO: mtime_cmp[31:0]  = wd;
					default:      mtime_cmp[63:32] = wd;
				endcase
			end
			CMD_TICK: begin
				if (!tick_armed) begin
					tick_armed = 1'b1;
				end else begin
					mtime_now = mtime_now + {32'd0, el};
					mip = csr_value(ADDR_MIP);
					if (mtime_cmp != '0 && mtime_now > mtime_cmp)
						mip = mip | BIT_MTIP;
					else
						mip = mip & MASK_NO_MTIP;
					csr_store_write(ADDR_MIP, mip);
					if ((csr_value(ADDR_MIP) & BIT_MTIP) != '0 &&
						(csr_value(ADDR_MIE) & BIT_MTIE) != '0 &&
						(csr_value(ADDR_MSTATUS) & BIT_MSTATUS_MIE) != '0)
						res.irq_cause = CAUSE_MTIMER;
				end
			end
			default: ;
		endcase
		due_results.push_back(res);
	endtask

	always @(posedge clk) begin
		csr_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					checked++;
					if (m_axis_tdata[63:32] == CAUSE_MTIMER)
						irq_taken++;
					if (m_axis_tdata[31:0] !== want.rdata) begin
						$display("%0t: rdata mismatch, expected %h, actual %h",
							$time, want.rdata, m_axis_tdata[31:0]);
						fail_count++;
					end
					if (m_axis_tdata[63:32] !== want.irq_cause) begin
						$display("%0t: irq_cause mismatch, expected %h, actual %h",
							$time, want.irq_cause, m_axis_tdata[63:32]);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				csr_timer_step(s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[13:12],
					s_axis_tdata[45:14], s_axis_tdata[77:46]);
			pending = due_results.size();
		end
	end

endmodule

@@ tb/sv/csr_file_with_machine_timer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_file_with_machine_timer_top_tb
// Drives CSR, timer and tick commands into the CSR file with machine timer:
// a directed pass over fixed registers, store extremes, mtime carry, the
// first tick, the compare edge and unused commands, then weighted random
// traffic with interrupt setup sequences. Both channels stall in random
// bursts except near the end. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module csr_file_with_machine_timer_top_tb;
	import cfmt_pkg::*;

	localparam int QUIET_LIMIT  = 20000;
	localparam int RANDOM_ITEMS = 1020;
	localparam int CALM_ITEMS   = 120;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata  = '0;  // csr_number, io_offset, wdata, elapsed, pad
	logic [2:0]  s_axis_tuser  = '0;  // cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;        // rdata, irq_cause

	int fail_count;
	int pending;
	int checked;
	int irq_taken;
	int sent         = 0;
	int ticks        = 0;
	int gap_pct      = 30;
	int stall_pct    = 15;
	int stall_left   = 0;
	int quiet_cycles = 0;
	bit calm         = 1'b0;

	always #5 clk = ~clk;

	csr_file_with_machine_timer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	csr_file_with_machine_timer_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.irq_taken     (irq_taken)
	);

	always @(posedge clk) begin
		if (calm) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(1, 9) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("csr_file_with_machine_timer_top_tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [2:0] cmd, input logic [11:0] csr,
		input logic [1:0] ofs, input logic [31:0] wd, input logic [31:0] el);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {2'b00, el, wd, ofs, csr};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
		if (cmd == CMD_TICK)
			ticks++;
	endtask

	function automatic logic [11:0] pick_csr();
		case ($urandom_range(0, 9))
			0:       return ADDR_MSTATUS;
			1:       return ADDR_MIE;
			2:       return ADDR_MIP;
			3:       return ADDR_MISA;
			4:       return ADDR_MVENDORID;
			5:       return 12'h000;
			6:       return 12'hFFF;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	// keep the high halves close together so the compare flips often
	function automatic logic [31:0] high_word();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return 32'($urandom_range(0, 2));
	endfunction

	function automatic logic [31:0] pick_elapsed();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return $urandom >> $urandom_range(0, 31);
	endfunction

	// mostly enable the interrupt, place mtime and mtimecmp near each other, tick, then read MIP
	task automatic irq_sequence();
		logic [31:0] wd;
		logic [31:0] hi;
		wd = $urandom;
		if ($urandom_range(0, 3) != 0)
			wd = wd | BIT_MSTATUS_MIE;
		send_item(CMD_CSR_WR, ADDR_MSTATUS, 2'($urandom), wd, $urandom);
		wd = $urandom;
		if ($urandom_range(0, 3) != 0)
			wd = wd | BIT_MTIE;
		send_item(CMD_CSR_WR, ADDR_MIE, 2'($urandom), wd, $urandom);
		hi = high_word();
		send_item(CMD_TIMER_WR, 12'($urandom), OFS_MTIME_HI, hi, $urandom);
		send_item(CMD_TIMER_WR, 12'($urandom), OFS_MTIME_LO, $urandom, $urandom);
		send_item(CMD_TIMER_WR, 12'($urandom), OFS_MTCMP_HI, hi + 32'($urandom_range(0, 1)),
			$urandom);
		send_item(CMD_TIMER_WR, 12'($urandom), OFS_MTCMP_LO, $urandom, $urandom);
		repeat ($urandom_range(2, 6))
			send_item(CMD_TICK, 12'($urandom), 2'($urandom), $urandom, pick_elapsed());
		send_item(CMD_CSR_RD, ADDR_MIP, 2'($urandom), $urandom, $urandom);
	endtask

	initial begin
		int base;
		int done;
		int next_phase;
		int pick;
		logic [1:0] ofs;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// fixed registers, cleared store, first tick only arms
		send_item(CMD_CSR_RD, ADDR_MISA, 2'd0, '0, '0);
		send_item(CMD_CSR_RD, ADDR_MVENDORID, 2'd0, '0, '0);
		send_item(CMD_CSR_RD, 12'h000, 2'd0, '0, '0);
		send_item(CMD_TIMER_RD, 12'h000, OFS_MTIME_LO, '0, '0);
		send_item(CMD_TICK, 12'h000, 2'd0, '0, 32'hFFFF_FFFF);
		send_item(CMD_TIMER_RD, 12'h000, OFS_MTIME_LO, '0, '0);
		send_item(CMD_CSR_WR, ADDR_MISA, 2'd0, 32'hFFFF_FFFF, '0);
		send_item(CMD_CSR_RD, ADDR_MISA, 2'd0, '0, '0);
		send_item(CMD_CSR_WR, ADDR_MVENDORID, 2'd0, 32'h0000_0000, '0);
		send_item(CMD_CSR_RD, ADDR_MVENDORID, 2'd0, '0, '0);
		send_item(CMD_CSR_WR, 12'hFFF, 2'd0, 32'hFFFF_FFFF, '0);
		send_item(CMD_CSR_RD, 12'hFFF, 2'd0, '0, '0);
		// carry out of the low half of mtime with compare still zero
		send_item(CMD_CSR_WR, ADDR_MSTATUS, 2'd0, BIT_MSTATUS_MIE, '0);
		send_item(CMD_CSR_WR, ADDR_MIE, 2'd0, BIT_MTIE, '0);
		send_item(CMD_TIMER_WR, 12'h000, OFS_MTIME_LO, 32'hFFFF_FFFF, '0);
		send_item(CMD_TIMER_WR, 12'h000, OFS_MTIME_HI, 32'h0000_0000, '0);
		send_item(CMD_TICK, 12'h000, 2'd0, '0, 32'd1);
		send_item(CMD_TIMER_RD, 12'h000, OFS_MTIME_HI, '0, '0);
		// equal does not fire, one past does
		send_item(CMD_TIMER_WR, 12'h000, OFS_MTCMP_LO, 32'h0000_0010, '0);
		send_item(CMD_TIMER_WR, 12'h000, OFS_MTCMP_HI, 32'h0000_0001, '0);
		send_item(CMD_TICK, 12'h000, 2'd0, '0, 32'h0000_0010);
		send_item(CMD_TICK, 12'h000, 2'd0, '0, 32'd1);
		send_item(CMD_CSR_RD, ADDR_MIP, 2'd0, '0, '0);
		send_item(CMD_TIMER_RD, 12'h000, OFS_MTCMP_LO, '0, '0);
		send_item(CMD_TIMER_RD, 12'h000, OFS_MTCMP_HI, '0, '0);
		send_item(CMD_TIMER_WR, 12'h000, OFS_MTCMP_HI, 32'hFFFF_FFFF, '0);
		send_item(CMD_TICK, 12'h000, 2'd0, '0, 32'd0);
		send_item(3'd5, 12'hFFF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(3'd6, 12'hFFF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(3'd7, 12'hFFF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		base = sent;
		done = 0;
		next_phase = 0;
		while (done < RANDOM_ITEMS) begin
			if (done >= next_phase) begin
				gap_pct    = 15 * $urandom_range(0, 3);
				stall_pct  = 10 * $urandom_range(0, 3);
				next_phase = next_phase + 100;
			end
			calm = done >= RANDOM_ITEMS - CALM_ITEMS;
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				send_item(CMD_CSR_RD, pick_csr(), 2'($urandom), $urandom, $urandom);
			end else if (pick < 40) begin
				send_item(CMD_CSR_WR, pick_csr(), 2'($urandom), $urandom, $urandom);
			end else if (pick < 48) begin
				send_item(CMD_TIMER_RD, 12'($urandom), 2'($urandom), $urandom, $urandom);
			end else if (pick < 60) begin
				ofs = 2'($urandom);
				send_item(CMD_TIMER_WR, 12'($urandom), ofs, ofs[0] ? high_word() : $urandom,
					$urandom);
			end else if (pick < 88) begin
				send_item(CMD_TICK, 12'($urandom), 2'($urandom), $urandom, pick_elapsed());
			end else if (pick < 95) begin
				irq_sequence();
			end else begin
				send_item(3'($urandom_range(5, 7)), 12'($urandom), 2'($urandom), $urandom,
					$urandom);
			end
			done = sent - base;
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);

		$display("Sent %0d commands including %0d ticks;", sent, ticks);
		$display("checked %0d results, %0d with a timer interrupt.", checked, irq_taken);
		if (fail_count == 0 && pending == 0)
			$display("csr_file_with_machine_timer_top_tb: PASS");
		else
			$display("csr_file_with_machine_timer_top_tb: FAIL");
		$finish;
	end

endmodule

@@ csr_file_with_machine_timer_top.f @@
rtl/cfmt_pkg.sv
rtl/csr_file_with_machine_timer_top.sv
rtl/cfmt_checker.sv
tb/sv/csr_file_with_machine_timer_checker.sv
tb/sv/csr_file_with_machine_timer_top_tb.sv
